>>> rtl/core/gtmp_pkg.sv
// Shared types and constants for the grid text map parser.
package gtmp_pkg;

    // Size bounds of the map.
    localparam int MAX_COLS = 4096;
    localparam int MAX_ROWS = 4096;

    // Field widths of the result transaction.
    localparam int POS_W = 12;
    localparam int DIM_W = 13;
    localparam int OFF_W = 32;

    // Counters must hold the bound itself and at least fill the size fields.
    localparam int CNT_RAW_W = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
    localparam int CNT_W = (CNT_RAW_W > DIM_W) ? CNT_RAW_W : DIM_W;

    // Characters of the map text.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   width;
        logic [OFF_W-1:0]   err_pos;
        logic               err_at_eof;
    } result_t;

endpackage

>>> rtl/core/gtmp_parse_core.sv
// Parser state and per-byte next-state and result logic.
module gtmp_parse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  gtmp_pkg::item_t  item,
    output logic             hit,
    output gtmp_pkg::result_t result
);
    import gtmp_pkg::*;

    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0] first_width_reg, first_width_next;
    logic             width_known_reg, width_known_next;
    logic             cr_pending_reg, cr_pending_next;
    logic             drain_reg, drain_next;
    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next;

    logic             row_open;
    logic             width_bad;
    logic [CNT_W-1:0] eof_width;
    logic [CNT_W-1:0] eof_rows;
    logic             is_cell;

    // Error result builder. A line end closes the row; mismatch is flagged just past the LF.
    function automatic void end_row_error(output result_t r, input logic [OFF_W-1:0] pos,
                                          input logic at_eof);
        r            = '0;
        r.kind       = KIND_ERROR;
        r.err_pos    = pos;
        r.err_at_eof = at_eof;
    endfunction

    always_comb
    begin
        col_count_next   = col_count_reg;
        row_count_next   = row_count_reg;
        first_width_next = first_width_reg;
        width_known_next = width_known_reg;
        cr_pending_next  = cr_pending_reg;
        drain_next       = drain_reg;
        byte_offset_next = byte_offset_reg;
        hit              = 1'b0;
        result           = '0;

        width_bad = width_known_reg && (col_count_reg != first_width_reg);
        row_open  = (row_count_reg == '0) || (col_count_reg != '0);
        eof_width = width_known_reg ? first_width_reg
                                    : (row_open ? col_count_reg : first_width_reg);
        eof_rows  = row_count_reg + {{(CNT_W-1){1'b0}}, row_open};
        is_cell   = (item.char_in == CH_HASH) || (item.char_in == CH_SPACE);

        if (item.end_of_file)
        begin
            // End of file always returns the parser to its reset state.
            if (drain_reg)
            begin
                hit = 1'b0;
            end
            else if (cr_pending_reg || (row_open && width_bad) || (eof_width == '0))
            begin
                hit = 1'b1;
                end_row_error(result, byte_offset_reg, 1'b1);
            end
            else
            begin
                hit           = 1'b1;
                result.kind   = KIND_DONE;
                result.height = eof_rows[DIM_W-1:0];
                result.width  = eof_width[DIM_W-1:0];
            end
            col_count_next   = '0;
            row_count_next   = '0;
            first_width_next = '0;
            width_known_next = 1'b0;
            cr_pending_next  = 1'b0;
            drain_next       = 1'b0;
            byte_offset_next = '0;
        end
        else
        begin
            byte_offset_next = byte_offset_reg + OFF_W'(1);
            if (drain_reg)
            begin
                hit = 1'b0;
            end
            else if ((cr_pending_reg && item.char_in == CH_LF) ||
                     (!cr_pending_reg && item.char_in == CH_LF &&
                      !(col_count_reg == '0 && row_count_reg >= CNT_W'(MAX_ROWS))))
            begin
                cr_pending_next = 1'b0;
                if (width_bad)
                begin
                    hit        = 1'b1;
                    drain_next = 1'b1;
                    end_row_error(result, byte_offset_reg + OFF_W'(1), 1'b0);
                end
                else
                begin
                    if (!width_known_reg)
                    begin
                        first_width_next = col_count_reg;
                        width_known_next = 1'b1;
                    end
                    row_count_next = row_count_reg + CNT_W'(1);
                    col_count_next = '0;
                end
            end
            else if (cr_pending_reg ||
                     (col_count_reg == '0 && row_count_reg >= CNT_W'(MAX_ROWS)) ||
                     (is_cell && col_count_reg >= CNT_W'(MAX_COLS)) ||
                     (!is_cell && item.char_in != CH_CR))
            begin
                // Lone CR, row or column bound, or a byte outside the alphabet.
                hit        = 1'b1;
                drain_next = 1'b1;
                end_row_error(result, byte_offset_reg, 1'b0);
            end
            else if (is_cell)
            begin
                if (item.char_in == CH_SPACE)
                begin
                    hit         = 1'b1;
                    result.kind = KIND_OPEN;
                    result.row  = row_count_reg[POS_W-1:0];
                    result.col  = col_count_reg[POS_W-1:0];
                end
                col_count_next = col_count_reg + CNT_W'(1);
            end
            else
            begin
                cr_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            first_width_reg <= '0;
            width_known_reg <= 1'b0;
            cr_pending_reg  <= 1'b0;
            drain_reg       <= 1'b0;
            byte_offset_reg <= '0;
        end
        else if (fire)
        begin
            col_count_reg   <= col_count_next;
            row_count_reg   <= row_count_next;
            first_width_reg <= first_width_next;
            width_known_reg <= width_known_next;
            cr_pending_reg  <= cr_pending_next;
            drain_reg       <= drain_next;
            byte_offset_reg <= byte_offset_next;
        end
    end

    // Once an error has been reported, text bytes produce nothing until end of file.
    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg && !item.end_of_file |-> !hit)
        else $error("result produced while draining after an error");

    // End of file leaves the counters and flags cleared.
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_file |=> (row_count_reg == '0) && (col_count_reg == '0) &&
                                     !drain_reg && !cr_pending_reg && !width_known_reg)
        else $error("parser state not cleared after end of file");

    // Counters never pass the size bounds.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (col_count_reg <= CNT_W'(MAX_COLS)) && (row_count_reg <= CNT_W'(MAX_ROWS)))
        else $error("row or column counter beyond its bound");

endmodule

>>> rtl/core/gtmp_out_buf.sv
// Result register between the parser and the downstream receiver.
module gtmp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              hit,
    input  gtmp_pkg::result_t data_in,
    input  logic              stall,
    output logic              ready,
    output logic              valid,
    output gtmp_pkg::result_t data
);
    import gtmp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The slot can take a new result when empty or being drained this cycle.
    assign ready = !valid_reg || !stall;

    always_comb
    begin
        if (load)
            valid_next = hit;
        else
            valid_next = valid_reg && stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && hit)
            data_reg <= data_in;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> rtl/core/grid_text_map_parser.sv
// Top level of the grid text map parser: input register, parser core, result register.
//
// Usage: the sender presents one byte of map text (or an end-of-file marker) per
// transaction on the item channel (item_valid, item_stall, item). The parser
// answers on the result channel (result_valid, result_stall, result) with at most
// one result transaction per item: an open cell with its row and column, the
// completed map with its height and width, or a syntax error with its byte offset.
// Items that produce nothing (walls, line ends, bytes dropped after an error)
// simply leave no result.
//
// An accepted item sits in the input register, and the parser logic writes its result
// into the result register once that register can take it. Throughput is one item
// per cycle while the receiver does not stall, as the row, column and offset counters
// for each item are computed combinationally.
//
// Reset clears both valid flags and all parser state; the block is ready at once.
// When the receiver stalls, the result register holds its transaction; the input
// register keeps its item and item_stall rises, so at most one item waits on each side.
module grid_text_map_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  gtmp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output gtmp_pkg::result_t result
);
    import gtmp_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    accept;
    logic    advance;
    logic    slot_ready;
    logic    core_hit;
    result_t core_result;

    // The held item moves on whenever the result register can take its outcome.
    assign advance    = in_valid_reg && slot_ready;
    assign item_stall = in_valid_reg && !slot_ready;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
    end

    gtmp_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .hit    (core_hit),
        .result (core_result)
    );

    gtmp_out_buf u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .hit     (core_hit),
        .data_in (core_result),
        .stall   (result_stall),
        .ready   (slot_ready),
        .valid   (result_valid),
        .data    (result)
    );

    // Backpressure reaches the sender only while an item is actually held.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
        else $error("item_stall raised with an empty input register");

    // A held item that is not advancing must still be held next cycle.
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input item lost or changed");

endmodule

>>> sim/grid_map_checker.sv
`timescale 1ns / 1ps
// Channel monitor for the grid text map parser: predicts each result and compares it.
module grid_map_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  gtmp_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  gtmp_pkg::result_t result,
    output int                mismatch_count,
    output int                results_due
);
    import gtmp_pkg::*;

    result_t     pending_parse_results[$];
    int          fail_tally = 0;
    int          due_count = 0;

    // Parser state as the text is read.
    logic [31:0] col_count;
    logic [31:0] row_count;
    logic [31:0] first_width;
    logic [31:0] byte_offset;
    logic        width_known;
    logic        cr_pending;
    logic        dropping;

    assign mismatch_count = fail_tally;
    assign results_due    = due_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_tally++;
    endtask

    task automatic clear_map_state();
        col_count   = '0;
        row_count   = '0;
        first_width = '0;
        byte_offset = '0;
        width_known = 1'b0;
        cr_pending  = 1'b0;
        dropping    = 1'b0;
    endtask

    task automatic flag_syntax_error(input logic [31:0] pos, input logic at_eof);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.err_pos    = pos;
        r.err_at_eof = at_eof;
        pending_parse_results.push_back(r);
        dropping = 1'b1;
    endtask

    // A line end closes the row; every row must match the first one's width.
    task automatic close_row(input logic [31:0] pos);
        cr_pending = 1'b0;
        if (width_known && col_count != first_width)
        begin
            flag_syntax_error(pos + 32'd1, 1'b0);
        end
        else
        begin
            if (!width_known)
            begin
                first_width = col_count;
                width_known = 1'b1;
            end
            row_count++;
            col_count = '0;
        end
    endtask

    task automatic finish_map();
        result_t r;
        logic    failed;
        failed = 1'b0;
        if (dropping)
        begin
            failed = 1'b1;
        end
        else if (cr_pending)
        begin
            flag_syntax_error(byte_offset, 1'b1);
        end
        else
        begin
            // An unterminated last row still counts, but a trailing line end opens none.
            if (row_count == 0 || col_count > 0)
            begin
                if (width_known && col_count != first_width)
                begin
                    flag_syntax_error(byte_offset, 1'b1);
                    failed = 1'b1;
                end
                else
                begin
                    if (!width_known)
                    begin
                        first_width = col_count;
                        width_known = 1'b1;
                    end
                    row_count++;
                end
            end
            if (!failed)
            begin
                if (first_width == 0)
                begin
                    flag_syntax_error(byte_offset, 1'b1);
                end
                else
                begin
                    r        = '0;
                    r.kind   = KIND_DONE;
                    r.height = row_count[DIM_W-1:0];
                    r.width  = first_width[DIM_W-1:0];
                    pending_parse_results.push_back(r);
                end
            end
        end
        clear_map_state();
    endtask

    task automatic parse_map_byte(input logic [7:0] ch);
        logic [31:0] pos;
        result_t     r;
        pos         = byte_offset;
        byte_offset = byte_offset + 32'd1;
        if (dropping)
            return;
        if (cr_pending)
        begin
            if (ch == CH_LF)
                close_row(pos);
            else
                flag_syntax_error(pos, 1'b0);
            return;
        end
        if (col_count == 0 && row_count >= MAX_ROWS)
        begin
            flag_syntax_error(pos, 1'b0);
            return;
        end
        if (ch == CH_HASH || ch == CH_SPACE)
        begin
            if (col_count >= MAX_COLS)
            begin
                flag_syntax_error(pos, 1'b0);
                return;
            end
            if (ch == CH_SPACE)
            begin
                r      = '0;
                r.kind = KIND_OPEN;
                r.row  = row_count[POS_W-1:0];
                r.col  = col_count[POS_W-1:0];
                pending_parse_results.push_back(r);
            end
            col_count++;
        end
        else if (ch == CH_CR)
        begin
            cr_pending = 1'b1;
        end
        else if (ch == CH_LF)
        begin
            close_row(pos);
        end
        else
        begin
            flag_syntax_error(pos, 1'b0);
        end
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.row !== want.row)
            report_mismatch("row", 32'(got.row), 32'(want.row));
        if (got.col !== want.col)
            report_mismatch("col", 32'(got.col), 32'(want.col));
        if (got.height !== want.height)
            report_mismatch("height", 32'(got.height), 32'(want.height));
        if (got.width !== want.width)
            report_mismatch("width", 32'(got.width), 32'(want.width));
        if (got.err_pos !== want.err_pos)
            report_mismatch("err_pos", got.err_pos, want.err_pos);
        if (got.err_at_eof !== want.err_at_eof)
            report_mismatch("err_at_eof", 32'(got.err_at_eof), 32'(want.err_at_eof));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_map_state();
            pending_parse_results.delete();
            due_count = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (item.end_of_file)
                    finish_map();
                else
                    parse_map_byte(item.char_in);
            end
            if (result_valid && !result_stall)
            begin
                if (pending_parse_results.size() == 0)
                    report_mismatch("result with nothing pending, kind", 32'(result.kind), 32'd0);
                else
                    compare_result(result, pending_parse_results.pop_front());
            end
            due_count = pending_parse_results.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the grid text map parser testbench: stimulus, flow control and verdict.
module testbench;
    import gtmp_pkg::*;

    // Random maps stop once about this many bytes that the parser really reads have gone in.
    localparam int RANDOM_ITEMS = 500;

    // Cycles without any transaction on either channel before the run is called hung.
    // The longest correct quiet stretch is a sender gap or a receiver stall, so this
    // leaves a wide margin.
    localparam int IDLE_LIMIT = 2000;

    // Flavors of random map. Each one sends a whole map and closes it with end of file.
    typedef enum int {
        FAULT_NONE,
        FAULT_BAD_BYTE,
        FAULT_LONE_CR,
        FAULT_CR_AT_EOF,
        FAULT_WIDTH,
        FAULT_NOISE
    } map_fault_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    item_t   item = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    int      mismatch_count;
    int      results_due;

    // Bytes counted toward RANDOM_ITEMS; counting pauses while the parser drops bytes.
    int      counted_items = 0;
    bit      counting = 1'b0;
    // Remaining transactions of a back-to-back burst with no sender gaps.
    int      no_gap_items = 0;
    // Set at the end so that the receiver stops stalling and the pipeline empties.
    logic    settle = 1'b0;

    int      stall_left = 0;
    int      stall_pick;
    int      idle_cycles = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    grid_text_map_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    grid_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // Gap after each transaction: mostly none or short, now and then long, and
    // sometimes a burst of dozens of transactions with no gap at all.
    task automatic next_gap(output int gap);
        int pick;
        if (no_gap_items > 0)
        begin
            no_gap_items--;
            gap = 0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                no_gap_items = $urandom_range(20, 80);
                gap = 0;
            end
            else if (pick < 55)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 2);
            else if (pick < 96)
                gap = $urandom_range(3, 6);
            else
                gap = $urandom_range(10, 30);
        end
    endtask

    // Presents one transaction and holds it until the parser takes it. When no gap
    // follows, valid simply stays high and the next call loads the next item in the
    // same step, so valid gets only one assignment per step.
    task automatic send_item(input logic [7:0] ch, input logic eof);
        int gap;
        item.char_in     <= ch;
        item.end_of_file <= eof;
        item_valid       <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (counting)
            counted_items++;
        next_gap(gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The byte that rides along with end of file is ignored, so it is random.
    task automatic send_eof();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_square();
        send_item(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_HASH, 1'b0);
    endtask

    task automatic send_line_end();
        if ($urandom_range(0, 1) != 0)
            send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
    endtask

    // Any byte that is neither a map character nor part of a line end.
    task automatic send_bad_byte();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_SPACE || ch == CH_HASH || ch == CH_CR || ch == CH_LF);
        send_item(ch, 1'b0);
    endtask

    // One random map. Most are well formed so the parser gets through whole rows;
    // the rest carry a single fault somewhere inside, or are plain noise.
    task automatic send_random_map();
        int         rows;
        int         cols;
        int         row_width;
        int         fault_row;
        int         fault_col;
        int         pick;
        int         noise_len;
        bit         last_terminated;
        map_fault_t fault;

        pick = $urandom_range(0, 99);
        if (pick < 60)
            fault = FAULT_NONE;
        else if (pick < 68)
            fault = FAULT_BAD_BYTE;
        else if (pick < 76)
            fault = FAULT_LONE_CR;
        else if (pick < 82)
            fault = FAULT_CR_AT_EOF;
        else if (pick < 92)
            fault = FAULT_WIDTH;
        else
            fault = FAULT_NOISE;

        if (fault == FAULT_NOISE)
        begin
            // Mostly map characters and line ends, so that noise still builds short rows now and then.
            noise_len = $urandom_range(0, 12);
            for (int i = 0; i < noise_len; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    send_square();
                else if (pick == 3)
                    send_item(CH_CR, 1'b0);
                else if (pick < 6)
                    send_item(CH_LF, 1'b0);
                else
                    send_item(8'($urandom), 1'b0);
            end
            send_eof();
            counting = 1'b1;
            return;
        end

        rows = $urandom_range(1, 6);
        cols = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        last_terminated = $urandom_range(0, 1);
        if (fault == FAULT_WIDTH)
        begin
            // A width fault needs a first row to compare against.
            if (rows < 2)
                rows = 2;
            fault_row = $urandom_range(1, rows - 1);
        end
        else
        begin
            fault_row = $urandom_range(0, rows - 1);
        end
        fault_col = $urandom_range(0, cols);

        for (int r = 0; r < rows; r++)
        begin
            row_width = cols;
            if (fault == FAULT_WIDTH && r == fault_row)
                row_width = (cols == 0 || $urandom_range(0, 1) != 0) ? cols + 1 : cols - 1;
            // Slot row_width stands for the line end, so faults can land right before it.
            for (int c = 0; c <= row_width; c++)
            begin
                if (r == fault_row && c == fault_col)
                begin
                    if (fault == FAULT_BAD_BYTE)
                    begin
                        send_bad_byte();
                        counting = 1'b0;
                    end
                    else if (fault == FAULT_LONE_CR)
                    begin
                        send_item(CH_CR, 1'b0);
                        pick = $urandom_range(0, 3);
                        if (pick == 0)
                            send_item(CH_CR, 1'b0);
                        else if (pick == 1)
                            send_bad_byte();
                        else
                            send_square();
                        counting = 1'b0;
                    end
                end
                if (c < row_width)
                    send_square();
                else if (r < rows - 1 || last_terminated)
                    send_line_end();
            end
        end
        if (fault == FAULT_CR_AT_EOF)
            send_item(CH_CR, 1'b0);
        send_eof();
        counting = 1'b1;
    endtask

    // Receiver flow control: free stretches of varied length, short stalls, long
    // free runs and the odd long stall. It goes quiet once the stimulus is over.
    always @(posedge clk)
    begin
        if (!rst_n || settle)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45)
            begin
                result_stall <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else if (stall_pick < 80)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else if (stall_pick < 92)
            begin
                result_stall <= 1'b0;
                stall_left = $urandom_range(40, 200);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    // Watchdog: a run that stops moving on both channels has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed maps: the smallest cases and each kind of error.
        send_eof();                              // empty text
        send_text(" ");                          // one open square, no line end
        send_eof();
        send_text("# \n #\n");                   // LF endings, trailing line end
        send_eof();
        send_text("# \015\n #");                 // CRLF ending, last row unterminated
        send_eof();
        send_text("\015");                       // CR right before end of file
        send_eof();
        send_text("#\015#");                     // CR followed by a square
        send_eof();                              // dropped after the error
        send_text("##\n#\n");                    // short row found at its LF
        send_eof();
        send_text("##\n#");                      // short last row found at end of file
        send_eof();
        send_text("\n\n");                       // rows of width zero only
        send_eof();
        send_item(8'hFF, 1'b0);                  // bad bytes with all bits set and clear
        send_eof();
        send_item(8'h00, 1'b0);
        send_eof();

        // Column bound: one square more than a row may hold.
        repeat (MAX_COLS) send_square();
        send_item(CH_HASH, 1'b0);
        send_eof();

        // Widest legal map: two full rows.
        repeat (2)
        begin
            repeat (MAX_COLS) send_square();
            send_line_end();
        end
        send_eof();

        // Tallest legal map, with a trailing line end that must not add a row.
        repeat (MAX_ROWS) send_text(" \n");
        send_eof();

        // Row bound: empty rows up to the limit, then any byte that would start one more.
        repeat (MAX_ROWS) send_item(CH_LF, 1'b0);
        case ($urandom_range(0, 3))
            0: send_item(CH_HASH, 1'b0);
            1: send_item(CH_SPACE, 1'b0);
            2: send_item(CH_CR, 1'b0);
            default: send_item(CH_LF, 1'b0);
        endcase
        send_eof();

        // Random maps.
        counting = 1'b1;
        while (counted_items < RANDOM_ITEMS)
            send_random_map();

        item_valid <= 1'b0;
        settle <= 1'b1;
        while (results_due != 0)
            @(posedge clk);
        // A stray result from the last items would show up here.
        repeat (10) @(posedge clk);
        // A predicted result that never came out counts as a failure too.
        if (mismatch_count == 0 && results_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gtmp_pkg.sv
rtl/core/gtmp_parse_core.sv
rtl/core/gtmp_out_buf.sv
rtl/core/grid_text_map_parser.sv
sim/grid_map_checker.sv
sim/testbench.sv
